// ----- sv/variable_length_record_store_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Record store assertion macros
// Shared forms for the concurrent checks of the record store.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_LENGTH_RECORD_STORE_UNIT_ASSERT_SVH
`define VARIABLE_LENGTH_RECORD_STORE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VLRS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("record store check failed");

// The consequent must hold in the cycle after the antecedent.
`define VLRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("record store check failed");

`endif

// ----- sv/vlrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Record store package
// Codes, controller states and the command and flag groups shared by the
// controller and the datapath of the record store.
// ----------------------------------------------------------------------------
`default_nettype none

package vlrs_pkg;

   localparam int unsigned STORE_BYTES_DEFAULT = 256;

   localparam logic [7:0] HEADER_BYTES = 8'd2;
   localparam logic [7:0] CAPACITY_RESET = 8'd255;

   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_GET = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [2:0] STATUS_OK = 3'd0;
   localparam logic [2:0] STATUS_NO_ROOM = 3'd1;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [2:0] STATUS_ADDR_RANGE = 3'd3;
   localparam logic [2:0] STATUS_ZERO_LENGTH = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_GET_ISSUE,
      ST_GET_CHECK
   } vlrs_state_type;

   typedef struct packed {
      logic append;
      logic noop_emit;
      logic read_issue;
      logic read_emit;
      logic get_start;
      logic get_issue;
      logic get_miss;
      logic get_hit;
      logic get_advance;
   } vlrs_cmd_type;

   typedef struct packed {
      logic walk_end;
      logic len_zero;
      logic idx_one;
   } vlrs_flags_type;

endpackage

`default_nettype wire

// ----- sv/variable_length_record_store_unit.sv -----
// ----------------------------------------------------------------------------
// Variable length record store
// Packs length-prefixed records into a byte store and looks them up.
// ----------------------------------------------------------------------------
// An append byte or an unused action is taken without leaving idle, so such
// transactions can be issued every cycle; busy stays low. A read holds busy
// for one cycle while the registered memory port returns the byte. A get
// walks the records through that same read port, an issue state and a check
// state per record visited, until a hit, a zero length byte, the end of the
// used store or an index of zero ends it. Every transaction yields one result,
// shown on the rsp_ ports with rsp_valid high for exactly one cycle, registered
// in the cycle after the transaction finishes; the receiver cannot stall it.
// Writing the capacity register clears the store at once, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_length_record_store_unit import vlrs_pkg::*; #(
   parameter int unsigned STORE_BYTES = STORE_BYTES_DEFAULT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_wr_en,
   input  wire logic [7:0]     csr_wr_data,
   input  wire logic           start,
   output logic                busy,
   input  wire logic [1:0]     req_action,
   input  wire logic [7:0]     req_data_byte,
   input  wire logic [7:0]     req_record_index,
   input  wire logic [7:0]     req_byte_address,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic [7:0]          rsp_record_offset,
   output logic [7:0]          rsp_record_length,
   output logic [7:0]          rsp_read_data,
   output logic                rsp_record_complete
);

   vlrs_cmd_type   cmd;
   vlrs_flags_type flags;

   vlrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .flags      (flags),
      .busy       (busy),
      .cmd        (cmd)
   );

   vlrs_datapath #(
      .STORE_BYTES (STORE_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_data_byte       (req_data_byte),
      .req_record_index    (req_record_index),
      .req_byte_address    (req_byte_address),
      .cmd                 (cmd),
      .flags               (flags),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_record_offset   (rsp_record_offset),
      .rsp_record_length   (rsp_record_length),
      .rsp_read_data       (rsp_read_data),
      .rsp_record_complete (rsp_record_complete)
   );

endmodule

`default_nettype wire

// ----- sv/vlrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Record store controller
// Sequences reads and record walks and issues commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module vlrs_ctrl import vlrs_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [1:0]     req_action,
   input  wire vlrs_flags_type flags,
   output logic                busy,
   output vlrs_cmd_type        cmd
);

   vlrs_state_type state_ff;
   vlrs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_action == ACT_GET) begin
                  state_in = ST_GET_ISSUE;
               end else if (req_action == ACT_READ) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_GET_ISSUE: begin
            state_in = flags.walk_end ? ST_IDLE : ST_GET_CHECK;
         end
         ST_GET_CHECK: begin
            state_in = (flags.len_zero || flags.idx_one) ? ST_IDLE : ST_GET_ISSUE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               unique case (req_action)
                  ACT_APPEND: cmd.append = 1'b1;
                  ACT_GET:    cmd.get_start = 1'b1;
                  ACT_READ:   cmd.read_issue = 1'b1;
                  default:    cmd.noop_emit = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            cmd.read_emit = 1'b1;
         end
         ST_GET_ISSUE: begin
            if (flags.walk_end) begin
               cmd.get_miss = 1'b1;
            end else begin
               cmd.get_issue = 1'b1;
            end
         end
         ST_GET_CHECK: begin
            priority if (flags.len_zero) begin
               cmd.get_miss = 1'b1;
            end else if (flags.idx_one) begin
               cmd.get_hit = 1'b1;
            end else begin
               cmd.get_advance = 1'b1;
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/vlrs_datapath.sv -----
// ----------------------------------------------------------------------------
// Record store datapath
// Byte memory, append pointers, record walk registers and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module vlrs_datapath import vlrs_pkg::*; #(
   parameter int unsigned STORE_BYTES = STORE_BYTES_DEFAULT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_wr_en,
   input  wire logic [7:0]     csr_wr_data,
   input  wire logic [7:0]     req_data_byte,
   input  wire logic [7:0]     req_record_index,
   input  wire logic [7:0]     req_byte_address,
   input  wire vlrs_cmd_type   cmd,
   output vlrs_flags_type      flags,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic [7:0]          rsp_record_offset,
   output logic [7:0]          rsp_record_length,
   output logic [7:0]          rsp_read_data,
   output logic                rsp_record_complete
);

   localparam int unsigned AW = $clog2(STORE_BYTES);
   localparam logic [8:0] STORE_LIMIT = 9'(STORE_BYTES);

   logic [7:0] mem [STORE_BYTES];

   logic [7:0] capacity_ff;
   logic [7:0] used_end_ff;
   logic [7:0] used_end_in;
   logic [7:0] append_ptr_ff;
   logic [7:0] append_ptr_in;
   logic [7:0] remaining_ff;
   logic [7:0] remaining_in;
   logic       dropping_ff;
   logic       dropping_in;

   logic [7:0] idx_ff;
   logic [8:0] cur_ff;
   logic [7:0] addr_ff;
   logic [7:0] rd_data_ff;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [2:0] rsp_status_ff;
   logic [2:0] rsp_status_in;
   logic [7:0] rsp_offset_ff;
   logic [7:0] rsp_offset_in;
   logic [7:0] rsp_length_ff;
   logic [7:0] rsp_length_in;
   logic [7:0] rsp_data_ff;
   logic [7:0] rsp_data_in;
   logic       rsp_complete_ff;
   logic       rsp_complete_in;

   logic [7:0] cap_floor;
   logic [7:0] eff_cap;
   logic [7:0] free_bytes;
   logic [7:0] rem_dec;
   logic [7:0] len_dec;
   logic [7:0] ptr_inc;
   logic [7:0] ptr_first;
   logic       mem_we;
   logic [7:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   logic [2:0] app_status;
   logic       app_done;

   assign cap_floor = (capacity_ff < HEADER_BYTES) ? HEADER_BYTES : capacity_ff;
   assign eff_cap = ({1'b0, cap_floor} > STORE_LIMIT) ? STORE_LIMIT[7:0] : cap_floor;
   assign free_bytes = (eff_cap > used_end_ff) ? (eff_cap - used_end_ff) : 8'd0;
   assign rem_dec = remaining_ff - 8'd1;
   assign len_dec = req_data_byte - 8'd1;
   assign ptr_inc = append_ptr_ff + 8'd1;
   assign ptr_first = used_end_ff + 8'd1;

   always_comb begin
      used_end_in = used_end_ff;
      append_ptr_in = append_ptr_ff;
      remaining_in = remaining_ff;
      dropping_in = dropping_ff;
      mem_we = 1'b0;
      mem_waddr = append_ptr_ff;
      app_status = STATUS_OK;
      app_done = 1'b0;
      if (cmd.append) begin
         if (remaining_ff == 8'd0) begin
            if (req_data_byte == 8'd0) begin
               app_status = STATUS_ZERO_LENGTH;
            end else if (req_data_byte > free_bytes) begin
               app_status = STATUS_NO_ROOM;
               remaining_in = len_dec;
               dropping_in = (len_dec != 8'd0);
               app_done = (len_dec == 8'd0);
            end else begin
               mem_we = 1'b1;
               mem_waddr = used_end_ff;
               append_ptr_in = ptr_first;
               remaining_in = len_dec;
               dropping_in = 1'b0;
               if (len_dec == 8'd0) begin
                  used_end_in = ptr_first;
                  app_done = 1'b1;
               end
            end
         end else if (dropping_ff) begin
            app_status = STATUS_NO_ROOM;
            remaining_in = rem_dec;
            if (rem_dec == 8'd0) begin
               dropping_in = 1'b0;
               app_done = 1'b1;
            end
         end else begin
            mem_we = 1'b1;
            append_ptr_in = ptr_inc;
            remaining_in = rem_dec;
            if (rem_dec == 8'd0) begin
               used_end_in = ptr_inc;
               app_done = 1'b1;
            end
         end
      end
      if (csr_wr_en) begin
         used_end_in = HEADER_BYTES;
         append_ptr_in = HEADER_BYTES;
         remaining_in = 8'd0;
         dropping_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         used_end_ff <= HEADER_BYTES;
         append_ptr_ff <= HEADER_BYTES;
         remaining_ff <= 8'd0;
         dropping_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         used_end_ff <= used_end_in;
         append_ptr_ff <= append_ptr_in;
         remaining_ff <= remaining_in;
         dropping_ff <= dropping_in;
      end
   end

   // Entries at or above the append pointer have not been written since the
   // last clear and read as zero.
   always_ff @(posedge clock) begin
      if (mem_we && ({1'b0, mem_waddr} < STORE_LIMIT)) begin
         mem[mem_waddr[AW-1:0]] <= req_data_byte;
      end
   end

   assign mem_raddr = cmd.get_issue ? cur_ff[AW-1:0] : req_byte_address[AW-1:0];

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.read_issue) begin
         addr_ff <= req_byte_address;
      end
      if (cmd.get_start) begin
         idx_ff <= req_record_index;
         cur_ff <= {1'b0, HEADER_BYTES};
      end else if (cmd.get_advance) begin
         idx_ff <= idx_ff - 8'd1;
         cur_ff <= cur_ff + {1'b0, rd_data_ff};
      end
   end

   always_comb begin
      flags.walk_end = (idx_ff == 8'd0) || (cur_ff >= {1'b0, used_end_ff});
      flags.len_zero = (rd_data_ff == 8'd0);
      flags.idx_one = (idx_ff == 8'd1);
   end

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_offset_in = 8'd0;
      rsp_length_in = 8'd0;
      rsp_data_in = 8'd0;
      rsp_complete_in = 1'b0;
      if (cmd.append) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = app_status;
         rsp_complete_in = app_done;
      end
      if (cmd.noop_emit) begin
         rsp_valid_in = 1'b1;
      end
      if (cmd.read_emit) begin
         rsp_valid_in = 1'b1;
         priority if (addr_ff >= eff_cap) begin
            rsp_status_in = STATUS_ADDR_RANGE;
         end else if (addr_ff == 8'd0) begin
            rsp_data_in = eff_cap;
         end else if (addr_ff == 8'd1) begin
            rsp_data_in = used_end_ff;
         end else if (addr_ff < append_ptr_ff) begin
            rsp_data_in = rd_data_ff;
         end else begin
            rsp_data_in = 8'd0;
         end
      end
      if (cmd.get_miss) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = STATUS_NOT_FOUND;
      end
      if (cmd.get_hit) begin
         rsp_valid_in = 1'b1;
         rsp_offset_in = cur_ff[7:0];
         rsp_length_in = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_length_ff <= rsp_length_in;
      rsp_data_ff <= rsp_data_in;
      rsp_complete_ff <= rsp_complete_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_record_offset = rsp_offset_ff;
   assign rsp_record_length = rsp_length_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_record_complete = rsp_complete_ff;

endmodule

`default_nettype wire

// ----- sv/vlrs_checker.sv -----
// ----------------------------------------------------------------------------
// Record store checker
// Port-level timing and result consistency checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "variable_length_record_store_unit_assert.svh"

module vlrs_checker import vlrs_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_action,
   input wire logic       rsp_valid,
   input wire logic [2:0] rsp_status,
   input wire logic [7:0] rsp_record_offset,
   input wire logic [7:0] rsp_record_length,
   input wire logic [7:0] rsp_read_data,
   input wire logic       rsp_record_complete
);

   logic accept_append;
   logic accept_read;
   logic complete_result;
   logic complete_code;
   logic range_result;
   logic range_fields_zero;

   assign accept_append = start && !busy && (req_action == ACT_APPEND);
   assign accept_read = start && !busy && (req_action == ACT_READ);
   assign complete_result = rsp_valid && rsp_record_complete;
   assign complete_code = (rsp_status == STATUS_OK) || (rsp_status == STATUS_NO_ROOM);
   assign range_result = rsp_valid && (rsp_status == STATUS_ADDR_RANGE);
   assign range_fields_zero = (rsp_read_data == 8'd0) && (rsp_record_length == 8'd0)
                              && (rsp_record_offset == 8'd0);

   `VLRS_ASSERT_NEXT(append_result_next, clock, reset, accept_append, rsp_valid)
   `VLRS_ASSERT_NEXT(read_two_cycles, clock, reset, accept_read, busy ##1 rsp_valid)
   `VLRS_ASSERT_SAME(walk_end_result, clock, reset, $fell(busy) && !$past(reset), rsp_valid)
   `VLRS_ASSERT_SAME(complete_status, clock, reset, complete_result, complete_code)
   `VLRS_ASSERT_SAME(range_zero_data, clock, reset, range_result, range_fields_zero)

endmodule

bind variable_length_record_store_unit vlrs_checker u_checker (.*);

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Record store testbench
// Drives append, get, read and unused transactions into the record store and
// checks every result against a behavioral model kept inside the bench or,
// for fixed rows, a fixed expectation. A short directed table comes first.
// Random phases follow at several capacities, most with random request gaps.
// ----------------------------------------------------------------------------
module testbench;
   import vlrs_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS = 220;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] offset;
      logic [7:0] length;
      logic [7:0] read_data;
      logic       complete;
   } record_result_type;

   typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_FIXED} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [1:0]        act;
      logic [7:0]        data;
      logic [7:0]        idx;
      logic [7:0]        addr;
      record_result_type want;
   } directed_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_action = ACT_APPEND;
   logic [7:0] req_data_byte = 8'd0;
   logic [7:0] req_record_index = 8'd0;
   logic [7:0] req_byte_address = 8'd0;
   logic       rsp_valid;
   logic [2:0] rsp_status;
   logic [7:0] rsp_record_offset;
   logic [7:0] rsp_record_length;
   logic [7:0] rsp_read_data;
   logic       rsp_record_complete;

   variable_length_record_store_unit dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_data_byte       (req_data_byte),
      .req_record_index    (req_record_index),
      .req_byte_address    (req_byte_address),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_record_offset   (rsp_record_offset),
      .rsp_record_length   (rsp_record_length),
      .rsp_read_data       (rsp_read_data),
      .rsp_record_complete (rsp_record_complete)
   );

   logic [7:0] store_image [0:255];
   logic [7:0] capacity_value;
   logic [7:0] committed_end;
   logic [7:0] fill_pointer;
   logic [7:0] bytes_left;
   logic       discarding;

   record_result_type pending_results [$];
   directed_row_type  directed_rows [$];

   int  error_count = 0;
   int  results_checked = 0;
   int  quiet_cycles = 0;
   int  action_counts [4] = '{0, 0, 0, 0};
   int  records_stored = 0;
   int  records_dropped = 0;
   int  capacity_writes = 0;
   bit  idle_enabled = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_image(input logic [7:0] value);
      capacity_value = value;
      foreach (store_image[i]) store_image[i] = 8'd0;
      committed_end = HEADER_BYTES;
      fill_pointer = HEADER_BYTES;
      bytes_left = 8'd0;
      discarding = 1'b0;
   endfunction

   function automatic record_result_type predict_record_op(input logic [1:0] act,
         input logic [7:0] data, input logic [7:0] idx, input logic [7:0] addr);
      record_result_type r;
      int cap;
      int free_bytes;
      int cursor;
      int index_left;
      int len;
      r = '0;
      cap = (capacity_value < 8'd2) ? 2 : int'(capacity_value);
      case (act)
         ACT_APPEND: begin
            if (bytes_left == 8'd0) begin
               free_bytes = (cap > int'(committed_end)) ? cap - int'(committed_end) : 0;
               if (data == 8'd0) begin
                  r.status = STATUS_ZERO_LENGTH;
               end else if (int'(data) > free_bytes) begin
                  r.status = STATUS_NO_ROOM;
                  bytes_left = data - 8'd1;
                  discarding = (bytes_left != 8'd0);
                  r.complete = (bytes_left == 8'd0);
               end else begin
                  store_image[committed_end] = data;
                  fill_pointer = committed_end + 8'd1;
                  bytes_left = data - 8'd1;
                  discarding = 1'b0;
                  if (bytes_left == 8'd0) begin
                     committed_end = fill_pointer;
                     r.complete = 1'b1;
                  end
               end
            end else if (discarding) begin
               r.status = STATUS_NO_ROOM;
               bytes_left = bytes_left - 8'd1;
               if (bytes_left == 8'd0) begin
                  discarding = 1'b0;
                  r.complete = 1'b1;
               end
            end else begin
               store_image[fill_pointer] = data;
               fill_pointer = fill_pointer + 8'd1;
               bytes_left = bytes_left - 8'd1;
               if (bytes_left == 8'd0) begin
                  committed_end = fill_pointer;
                  r.complete = 1'b1;
               end
            end
         end
         ACT_GET: begin
            cursor = int'(HEADER_BYTES);
            index_left = int'(idx);
            r.status = STATUS_NOT_FOUND;
            while (index_left != 0 && cursor < int'(committed_end)) begin
               len = int'(store_image[cursor]);
               if (len == 0) break;
               index_left--;
               if (index_left == 0) begin
                  r.status = STATUS_OK;
                  r.offset = cursor[7:0];
                  r.length = len[7:0];
                  break;
               end
               cursor += len;
            end
         end
         ACT_READ: begin
            if (int'(addr) >= cap) r.status = STATUS_ADDR_RANGE;
            else if (addr == 8'd0) r.read_data = cap[7:0];
            else if (addr == 8'd1) r.read_data = committed_end;
            else r.read_data = store_image[addr];
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic report_failure(input string what, input int want, input int got);
      error_count++;
      if (error_count <= 10)
         $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_enabled || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   task automatic issue_request(input logic [1:0] act, input logic [7:0] data,
         input logic [7:0] idx, input logic [7:0] addr,
         input bit use_fixed, input record_result_type fixed_want);
      int gap;
      record_result_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_data_byte <= data;
      req_record_index <= idx;
      req_byte_address <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = predict_record_op(act, data, idx, addr);
      pending_results.push_back(use_fixed ? fixed_want : predicted);
      action_counts[act]++;
      if (predicted.complete && predicted.status == STATUS_OK) records_stored++;
      if (predicted.complete && predicted.status == STATUS_NO_ROOM) records_dropped++;
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [7:0] value);
      wait_for_drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      clear_image(value);
      capacity_writes++;
   endtask

   task automatic add_row(input row_kind_type kind, input logic [1:0] act,
         input logic [7:0] data, input logic [7:0] idx, input logic [7:0] addr,
         input logic [2:0] status, input logic [7:0] read_data, input logic complete);
      directed_row_type row;
      row.kind = kind;
      row.act = act;
      row.data = data;
      row.idx = idx;
      row.addr = addr;
      row.want = '{status: status, offset: 8'd0, length: 8'd0,
                   read_data: read_data, complete: complete};
      directed_rows.push_back(row);
   endtask

   function automatic logic [7:0] pick_record_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return 8'd0;
      if (roll < 72) return 8'($urandom_range(1, 8));
      if (roll < 95) return 8'($urandom_range(1, 40));
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] pick_index();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 48));
   endfunction

   task automatic issue_lookup();
      if ($urandom_range(0, 1) == 0)
         issue_request(ACT_GET, 8'($urandom_range(0, 255)), pick_index(),
                       8'($urandom_range(0, 255)), 1'b0, '0);
      else
         issue_request(ACT_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   task automatic run_random_phase(input int budget);
      int issued;
      int roll;
      int cut;
      int k;
      bit paused;
      logic [7:0] len;
      issued = 0;
      paused = 1'b0;
      while (issued < budget) begin
         if (!paused && issued >= budget / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 62) begin
            len = pick_record_length();
            issue_request(ACT_APPEND, len, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'b0, '0);
            issued++;
            cut = ($urandom_range(0, 19) == 0 && len > 8'd1)
                  ? int'($urandom_range(1, int'(len) - 1)) : int'(len);
            for (k = 1; k < cut; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  issue_lookup();
                  issued++;
               end
               issue_request(ACT_APPEND, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             1'b0, '0);
               issued++;
            end
         end else if (roll < 93) begin
            issue_lookup();
            issued++;
         end else if (roll < 97) begin
            issue_request(ACT_UNUSED, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'b0, '0);
            issued++;
         end else begin
            issue_request(ACT_APPEND, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'b0, '0);
            issued++;
         end
      end
   endtask

   always @(posedge clock) begin
      record_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            report_failure("unexpected result", 0, 1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_failure("status", int'(want.status), int'(rsp_status));
            if (rsp_record_offset !== want.offset)
               report_failure("record_offset", int'(want.offset), int'(rsp_record_offset));
            if (rsp_record_length !== want.length)
               report_failure("record_length", int'(want.length), int'(rsp_record_length));
            if (rsp_read_data !== want.read_data)
               report_failure("read_data", int'(want.read_data), int'(rsp_read_data));
            if (rsp_record_complete !== want.complete)
               report_failure("record_complete", int'(want.complete),
                              int'(rsp_record_complete));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d transactions pending", pending_results.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase_caps [9];
      int p;
      logic [7:0] cap_choice;
      phase_caps = '{255, 2, 3, 255, 100, 0, 40, 0, 255};
      clear_image(CAPACITY_RESET);

      add_row(ROW_FIXED, ACT_READ, 8'h00, 8'h00, 8'd0, STATUS_OK, CAPACITY_RESET, 1'b0);
      add_row(ROW_FIXED, ACT_READ, 8'h00, 8'h00, 8'd1, STATUS_OK, HEADER_BYTES, 1'b0);
      add_row(ROW_FIXED, ACT_READ, 8'hff, 8'hff, 8'd255, STATUS_ADDR_RANGE, 8'd0, 1'b0);
      add_row(ROW_FIXED, ACT_GET, 8'h00, 8'd0, 8'd0, STATUS_NOT_FOUND, 8'd0, 1'b0);
      add_row(ROW_FIXED, ACT_GET, 8'h00, 8'd1, 8'd0, STATUS_NOT_FOUND, 8'd0, 1'b0);
      add_row(ROW_FIXED, ACT_APPEND, 8'd0, 8'd0, 8'd0, STATUS_ZERO_LENGTH, 8'd0, 1'b0);
      add_row(ROW_FIXED, ACT_UNUSED, 8'hff, 8'hff, 8'hff, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_APPEND, 8'd3, 8'd0, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_APPEND, 8'haa, 8'd0, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_APPEND, 8'h55, 8'd0, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_APPEND, 8'd1, 8'd0, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_APPEND, 8'd4, 8'd0, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_GET, 8'd0, 8'd3, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_APPEND, 8'hff, 8'd0, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_READ, 8'd0, 8'd0, 8'd7, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_APPEND, 8'h00, 8'd0, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_APPEND, 8'h80, 8'd0, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_GET, 8'd0, 8'd3, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_CFG, ACT_APPEND, 8'd4, 8'd0, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_FIXED, ACT_APPEND, 8'd3, 8'd0, 8'd0, STATUS_NO_ROOM, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_APPEND, 8'h12, 8'd0, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_APPEND, 8'h34, 8'd0, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_APPEND, 8'd2, 8'd0, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_APPEND, 8'h7e, 8'd0, 8'd0, STATUS_OK, 8'd0, 1'b0);
      add_row(ROW_FIXED, ACT_APPEND, 8'd1, 8'd0, 8'd0, STATUS_NO_ROOM, 8'd0, 1'b1);
      add_row(ROW_FIXED, ACT_READ, 8'd0, 8'd0, 8'd4, STATUS_ADDR_RANGE, 8'd0, 1'b0);
      add_row(ROW_PREDICT, ACT_GET, 8'd0, 8'd255, 8'd0, STATUS_OK, 8'd0, 1'b0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            set_capacity(directed_rows[i].data);
         end else begin
            issue_request(directed_rows[i].act, directed_rows[i].data,
                          directed_rows[i].idx, directed_rows[i].addr,
                          directed_rows[i].kind == ROW_FIXED, directed_rows[i].want);
         end
      end

      for (p = 0; p < 9; p++) begin
         cap_choice = (phase_caps[p] != 0) ? 8'(phase_caps[p]) : 8'($urandom_range(2, 255));
         set_capacity(cap_choice);
         idle_enabled = (p % 3 != 1);
         run_random_phase(PHASE_ITEMS);
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_failure("results never returned", 0, pending_results.size());

      $display("Ran %0d appends, %0d gets, %0d reads and %0d unused transactions over %0d %s",
               action_counts[ACT_APPEND], action_counts[ACT_GET], action_counts[ACT_READ],
               action_counts[ACT_UNUSED], capacity_writes, "capacity settings.");
      $display("Checked %0d results; %0d records stored, %0d records dropped for lack of room.",
               results_checked, records_stored, records_dropped);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/vlrs_pkg.sv
sv/vlrs_ctrl.sv
sv/vlrs_datapath.sv
sv/variable_length_record_store_unit.sv
sv/vlrs_checker.sv
test/testbench.sv
